[hdl/ordl_pkg.sv]
// ordl_pkg: shared sizes, codes and transaction types of the display list builder
// no dependencies; imported by ordering_table_display_list_builder

package ordl_pkg;

  // sizes of the ring and of the ordering table (both powers of two)
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned QUEUE_WORDS   = 32768;
  localparam int unsigned IDX_W         = $clog2(QUEUE_WORDS);
  localparam int unsigned TAB_W         = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LINK_W  = 24;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned RIDX_W  = 15;

  // header word layout
  localparam logic [WORD_W-1:0] LINK_MASK  = 32'h00FF_FFFF;
  localparam logic [WORD_W-1:0] COUNT_MASK = 32'hFF00_0000;

  // operation codes
  typedef enum logic [2:0] {
    OP_NEW_BLOCK = 3'd0,
    OP_BEGIN     = 3'd1,
    OP_PAYLOAD   = 3'd2,
    OP_FLUSH     = 3'd3,
    OP_READ      = 3'd4
  } op_e;

  // result kinds
  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  // input transaction
  typedef struct packed {
    op_e                operation;
    logic [COUNT_W-1:0] word_count;
    logic [DEPTH_W-1:0] depth;
    logic               in_front;
    logic [WORD_W-1:0]  payload;
    logic [RIDX_W-1:0]  read_index;
  } in_t;

  // output transaction
  typedef struct packed {
    kind_e             result_kind;
    logic [WORD_W-1:0] result_word;
  } out_t;

endpackage

[hdl/ordl_ram.sv]
// ordl_ram: generic single write port, single read port memory
// registered read data that holds while no read is issued; no dependencies

module ordl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read; a read of the address written in the same cycle returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/ordering_table_display_list_builder.sv]
// ordering_table_display_list_builder: linked display list in a ring of 32-bit words
// depends on ordl_pkg and ordl_ram
//
//   channel | direction | handshake          | contents
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid_i/stall_o | in_t: operation and its operands
//   out     | output    | out_valid_o/stall_i| out_t: read data or list start
//   cfg     | input     | cfg_valid_i/ready_o| queue base byte address (24 bit)
//
// payload word: written as it is taken; begin primitive, read word: one memory access
// then a read-modify-write or the registered read data of the single ring memory.
// new block and flush: each ends in the table sweep that writes one bucket word per cycle
// through the one write port.
// reset clears all pointers; the ring itself is not cleared.
// the output register frees the input side: a result waits there under out_stall_i
// while the next transaction is taken; a read or flush waits only for that register.

module ordering_table_display_list_builder
  import ordl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LINK_W-1:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT,
    ST_BUCKET,
    ST_READ,
    ST_FLUSH,
    ST_OPEN,
    ST_TABLE
  } state_e;

  typedef logic [IDX_W-1:0] idx_t;

  state_e             state_q, state_d;
  idx_t               end_q, end_d;
  idx_t               table_q, table_d;
  idx_t               list_q, list_d;
  idx_t               ft_q, ft_d;
  idx_t               fill_q, fill_d;
  idx_t               head_q, head_d;
  logic [LINK_W-1:0]  base_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               fwd_q, fwd_d;
  logic [TAB_W-1:0]   sweep_q, sweep_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;

  // memory port
  logic               ram_we;
  idx_t               ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  idx_t               ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic               in_acc;
  logic               out_free;

  // begin primitive placement
  logic [IDX_W:0]     bp_sum;
  logic               bp_wrap;
  idx_t               bp_head;
  idx_t               bp_end;
  idx_t               bp_bucket;
  logic [WORD_W-1:0]  bp_hdr;

  // new block placement
  logic [IDX_W:0]     ob_sum;
  idx_t               ob_end;
  idx_t               ob_table;

  // sweep address
  idx_t               sw_addr;
  logic [WORD_W-1:0]  old_ft;

  // byte address link of a ring word
  function automatic logic [LINK_W-1:0] link_of(input logic [LINK_W-1:0] base,
                                                input idx_t i);
    return base + LINK_W'({i, 2'b00});
  endfunction

  ordl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_WORDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // begin primitive: reserve header plus payload words, wrap to word zero
  always_comb begin
    bp_sum    = {1'b0, end_q} + (IDX_W+1)'(in_data_i.word_count) + (IDX_W+1)'(1);
    bp_wrap   = (bp_sum >= (IDX_W+1)'(QUEUE_WORDS));
    bp_head   = bp_wrap ? '0 : end_q;
    bp_end    = bp_wrap ? (idx_t'(in_data_i.word_count) + idx_t'(1)) : bp_sum[IDX_W-1:0];
    bp_bucket = table_q + idx_t'(TAB_W'(in_data_i.depth));
    bp_hdr    = {in_data_i.word_count, LINK_MASK[LINK_W-1:0]};
  end

  // new block: reserve front word plus table, wrap when it does not fit
  always_comb begin
    ob_sum   = {1'b0, end_q} + (IDX_W+1)'(TABLE_ENTRIES + 1);
    ob_end   = (ob_sum >= (IDX_W+1)'(QUEUE_WORDS)) ? idx_t'(TABLE_ENTRIES + 1)
                                                    : ob_sum[IDX_W-1:0];
    ob_table = ob_end - idx_t'(TABLE_ENTRIES);
  end

  assign sw_addr = table_q + idx_t'(sweep_q);
  assign old_ft  = fwd_q ? {cnt_q, LINK_MASK[LINK_W-1:0]} : ram_rdata;

  // sequencer and memory port control
  always_comb begin
    state_d     = state_q;
    end_d       = end_q;
    table_d     = table_q;
    list_d      = list_q;
    ft_d        = ft_q;
    fill_d      = fill_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    fwd_d       = fwd_q;
    sweep_d     = sweep_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.operation)
            OP_NEW_BLOCK: begin
              state_d = ST_OPEN;
            end
            OP_BEGIN: begin
              end_d  = bp_end;
              head_d = bp_head;
              cnt_d  = in_data_i.word_count;
              fill_d = bp_head + idx_t'(1);
              if (in_data_i.in_front) begin
                // header goes in now, old front tail is read alongside
                ram_we    = 1'b1;
                ram_waddr = bp_head;
                ram_wdata = bp_hdr;
                ram_re    = 1'b1;
                ram_raddr = ft_q;
                fwd_d     = (ft_q == bp_head);
                state_d   = ST_FRONT;
              end else begin
                // bucket gets the new link, its old contents come back next cycle
                ram_we    = 1'b1;
                ram_waddr = bp_bucket;
                ram_wdata = WORD_W'(link_of(base_q, bp_head));
                ram_re    = 1'b1;
                ram_raddr = bp_bucket;
                fwd_d     = (bp_bucket == bp_head);
                state_d   = ST_BUCKET;
              end
            end
            OP_PAYLOAD: begin
              ram_we    = 1'b1;
              ram_waddr = fill_q;
              ram_wdata = in_data_i.payload;
              fill_d    = fill_q + idx_t'(1);
            end
            OP_FLUSH: begin
              state_d = ST_FLUSH;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = idx_t'(in_data_i.read_index);
              state_d   = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      ST_FRONT: begin
        // splice after the old front tail, keep its count byte
        ram_we    = 1'b1;
        ram_waddr = ft_q;
        ram_wdata = (old_ft & COUNT_MASK) | WORD_W'(link_of(base_q, head_q));
        ft_d      = head_q;
        state_d   = ST_IDLE;
      end

      ST_BUCKET: begin
        // header takes the bucket's old link; bucket wins where both are one word
        ram_we    = !fwd_q;
        ram_waddr = head_q;
        ram_wdata = ram_rdata | {cnt_q, {LINK_W{1'b0}}};
        state_d   = ST_IDLE;
      end

      ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{result_kind: KIND_READ, result_word: ram_rdata};
          state_d     = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{result_kind: KIND_FLUSH,
                          result_word: WORD_W'(link_of(base_q, list_q))};
          state_d     = ST_OPEN;
        end
      end

      ST_OPEN: begin
        // place the new block and write the terminator into the front word
        end_d     = ob_end;
        list_d    = ob_end - idx_t'(1);
        table_d   = ob_table;
        ft_d      = ob_table - idx_t'(1);
        ram_we    = 1'b1;
        ram_waddr = ob_table - idx_t'(1);
        ram_wdata = LINK_MASK;
        sweep_d   = '0;
        state_d   = ST_TABLE;
      end

      ST_TABLE: begin
        // each bucket links to the word below it
        ram_we    = 1'b1;
        ram_waddr = sw_addr;
        ram_wdata = WORD_W'(link_of(base_q, sw_addr - idx_t'(1)));
        sweep_d   = sweep_q + TAB_W'(1);
        if (sweep_q == TAB_W'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      end_q       <= '0;
      table_q     <= '0;
      list_q      <= '0;
      ft_q        <= '0;
      fill_q      <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      fwd_q       <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      end_q       <= end_d;
      table_q     <= table_d;
      list_q      <= list_d;
      ft_q        <= ft_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      fwd_q       <= fwd_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // queue base address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  // no memory write while a result waits for the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_FLUSH) |-> !ram_we)
    else $error("ring written while a result is pending");

  // a new result only comes from the read or flush wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_FLUSH))
    else $error("result raised outside read or flush");

  // the fill pointer starts right after the new header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRONT || state_q == ST_BUCKET) |-> (fill_q == head_q + idx_t'(1)))
    else $error("fill pointer not behind header");

  // the table sweep ends after its last bucket
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TABLE && sweep_q == TAB_W'(TABLE_ENTRIES - 1)) |=> (state_q == ST_IDLE))
    else $error("table sweep overran");

  // a flush always goes on to open a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && out_free) |=> (state_q == ST_OPEN))
    else $error("flush did not open a new block");
`endif

endmodule

[bench/ordering_table_display_list_builder_tb.sv]
// ordering_table_display_list_builder_tb: self-checking bench for the display list builder
// depends on ordl_pkg and ordering_table_display_list_builder (with its ring memory)
// directed rows first, then random well-formed primitive sequences under three idle mixes

module ordering_table_display_list_builder_tb
  import ordl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned WATCHDOG_MAX = 20000;
  localparam int unsigned SETTLE_WAIT  = TABLE_ENTRIES + 16;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 306;
  localparam int unsigned RECENT_MAX   = 32;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [LINK_W-1:0] BASE_TOP = 24'hFF_FFFC;

  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [LINK_W-1:0] cfg_data_i;

  ordering_table_display_list_builder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the ring and the list pointers
  logic [WORD_W-1:0] ring_mem [QUEUE_WORDS];
  bit                ring_set [QUEUE_WORDS];
  int unsigned       recent_idx[$];
  int unsigned       tab_base, list_head, end_ptr, front_ptr, fill_ptr;
  logic [LINK_W-1:0] base_addr;

  out_t awaited_results[$];

  int errors, items_in, results_seen, flushes_seen, base_writes;
  int block_wraps, prim_wraps, payloads_left, quiet_cycles;
  int send_idle_pct = 26;
  int recv_idle_pct = 81;
  bit hold_req;

  // clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // byte address link to a ring word
  function automatic logic [WORD_W-1:0] link_to(int unsigned idx);
    return ({8'h00, base_addr} + (idx % QUEUE_WORDS) * 4) & LINK_MASK;
  endfunction

  function automatic void store_word(int unsigned idx, logic [WORD_W-1:0] value);
    int unsigned w;
    w = idx % QUEUE_WORDS;
    ring_mem[w] = value;
    ring_set[w] = 1'b1;
    recent_idx.push_back(w);
    if (recent_idx.size() > RECENT_MAX) void'(recent_idx.pop_front());
  endfunction

  // reserve a fresh ordering table with its front-list terminator
  function automatic void open_table();
    end_ptr += TABLE_ENTRIES + 1;
    if (end_ptr >= QUEUE_WORDS) begin
      end_ptr = TABLE_ENTRIES + 1;
      block_wraps++;
    end
    end_ptr   = end_ptr % QUEUE_WORDS;
    list_head = (end_ptr + QUEUE_WORDS - 1) % QUEUE_WORDS;
    tab_base  = (end_ptr + QUEUE_WORDS - TABLE_ENTRIES) % QUEUE_WORDS;
    front_ptr = (tab_base + QUEUE_WORDS - 1) % QUEUE_WORDS;
    store_word(front_ptr, LINK_MASK);
    for (int unsigned b = 0; b < TABLE_ENTRIES; b++)
      store_word(tab_base + b, link_to(tab_base + b + QUEUE_WORDS - 1));
  endfunction

  // splice a primitive header into a bucket or after the front tail
  function automatic void splice_header(logic [COUNT_W-1:0] cnt, logic [DEPTH_W-1:0] dep,
                                        logic frt);
    int unsigned head, bucket;
    head = end_ptr;
    end_ptr += cnt + 1;
    if (end_ptr >= QUEUE_WORDS) begin
      end_ptr = cnt + 1;
      head = 0;
      prim_wraps++;
    end
    head    = head % QUEUE_WORDS;
    end_ptr = end_ptr % QUEUE_WORDS;
    if (frt) begin
      store_word(head, LINK_MASK | {cnt, 24'h0});
      store_word(front_ptr, (ring_mem[front_ptr] & COUNT_MASK) | link_to(head));
      front_ptr = head;
    end else begin
      bucket = (tab_base + dep % TABLE_ENTRIES) % QUEUE_WORDS;
      store_word(head, ring_mem[bucket] | {cnt, 24'h0});
      store_word(bucket, link_to(head));
    end
    fill_ptr = (head + 1) % QUEUE_WORDS;
  endfunction

  // applies one transaction to the shadow state; returns 1 when it yields a result
  function automatic bit predict_list_op(in_t it, output out_t res);
    res = '0;
    case (it.operation)
      OP_NEW_BLOCK: open_table();
      OP_BEGIN:     splice_header(it.word_count, it.depth, it.in_front);
      OP_PAYLOAD: begin
        store_word(fill_ptr, it.payload);
        fill_ptr = (fill_ptr + 1) % QUEUE_WORDS;
      end
      OP_FLUSH: begin
        res.result_kind = KIND_FLUSH;
        res.result_word = link_to(list_head);
        open_table();
        return 1'b1;
      end
      OP_READ: begin
        res.result_kind = KIND_READ;
        res.result_word = ring_mem[it.read_index];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // a ring index that has been written, mostly spread over the whole ring
  function automatic logic [RIDX_W-1:0] pick_written();
    int unsigned r;
    repeat (32) begin
      r = $urandom_range(0, QUEUE_WORDS - 1);
      if (ring_set[r]) return RIDX_W'(r);
    end
    return RIDX_W'(recent_idx[$urandom_range(0, recent_idx.size() - 1)]);
  endfunction

  function automatic stim_row_t stim(op_e op, logic [COUNT_W-1:0] cnt, logic [DEPTH_W-1:0] dep,
                                    logic frt, logic [WORD_W-1:0] pay,
                                    logic [RIDX_W-1:0] ridx, bit fixed = 1'b0,
                                    kind_e k = KIND_READ, logic [WORD_W-1:0] w = '0);
    stim_row_t r;
    r.item.operation  = op;
    r.item.word_count = cnt;
    r.item.depth      = dep;
    r.item.in_front   = frt;
    r.item.payload    = pay;
    r.item.read_index = ridx;
    r.fixed           = fixed;
    r.want.result_kind = k;
    r.want.result_word = w;
    return r;
  endfunction

  // random transaction: begin followed by its payload words, reads, rare table ops and noise
  function automatic in_t make_random(bit read_only);
    in_t it;
    int  roll;
    bit  block_wrap_due, block_ok;
    it.word_count = COUNT_W'($urandom_range(0, 255));
    it.depth      = DEPTH_W'($urandom_range(0, 1023));
    it.in_front   = ($urandom_range(0, 99) < 30);
    it.payload    = $urandom;
    it.read_index = RIDX_W'($urandom_range(0, QUEUE_WORDS - 1));
    it.operation  = OP_READ;
    // alternate ring passes between a table op and a primitive taking the wrap
    block_wrap_due = (end_ptr + TABLE_ENTRIES + 1 >= QUEUE_WORDS);
    block_ok = !block_wrap_due || ((block_wraps + prim_wraps) % 2 == 1);
    roll = $urandom_range(0, 99);
    if (read_only) begin
      it.operation = OP_READ;
    end else if (payloads_left > 0 && roll < 88) begin
      it.operation = OP_PAYLOAD;
      payloads_left--;
    end else if (block_wrap_due && block_ok) begin
      it.operation = (roll % 2) ? OP_FLUSH : OP_NEW_BLOCK;
      payloads_left = 0;
    end else begin
      payloads_left = 0;
      roll = $urandom_range(0, 99);
      if (roll < 4 && block_ok) it.operation = OP_NEW_BLOCK;
      else if (roll < 7 && block_ok) it.operation = OP_FLUSH;
      else if (roll < 35) it.operation = OP_BEGIN;
      else if (roll < 75) it.operation = OP_READ;
      else if (roll < 78) it.operation = OP_PAYLOAD;
      else if (roll < 80) it.operation = op_e'(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
      else it.operation = OP_READ;
      if (it.operation == OP_BEGIN) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) it.word_count = COUNT_W'($urandom_range(0, 8));
        else if (roll >= 90) it.word_count = 8'hFF;
        payloads_left = (it.word_count <= 8) ? it.word_count : $urandom_range(0, 4);
      end
    end
    if (it.operation == OP_READ) it.read_index = pick_written();
    return it;
  endfunction

  // offer one transaction, update the shadow on acceptance
  task automatic push_item(in_t it, bit fixed = 1'b0, out_t want = '0);
    out_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_in++;
    if (predict_list_op(it, predicted)) awaited_results.push_back(fixed ? want : predicted);
    @(negedge clk_i);
  endtask

  // sender pause: every result back, then room for a running table sweep
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_base(logic [LINK_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    base_addr = value;
    base_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (out_data_o.result_kind == KIND_FLUSH) flushes_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing awaited: kind %0d word %h", $time,
                 out_data_o.result_kind, out_data_o.result_word);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.result_kind !== want.result_kind) begin
          $display("%0t: result_kind expected %0d actual %0d", $time,
                   want.result_kind, out_data_o.result_kind);
          errors++;
        end
        if (out_data_o.result_word !== want.result_word) begin
          $display("%0t: result_word expected %h actual %h", $time,
                   want.result_word, out_data_o.result_word);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("ordering_table_display_list_builder_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t rows[$];
    int        n;
    in_t       it;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    base_addr   = '0;
    tab_base = 0; list_head = 0; end_ptr = 0; front_ptr = 0; fill_ptr = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // top base address so links wrap past 24 bits
    write_base(BASE_TOP);

    // directed: use before new block, extremes, front list, stray payloads, unused codes
    rows.push_back(stim(OP_PAYLOAD, 8'h00, 10'h000, 1'b0, 32'hFFFF_FFFF, 15'd0));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0,
                        1'b1, KIND_READ, 32'hFFFF_FFFF));
    rows.push_back(stim(OP_BEGIN, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_FLUSH, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0,
                        1'b1, KIND_FLUSH, 32'h00FF_FFFC));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1,
                        1'b1, KIND_READ, 32'h00FF_FFFF));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd2));
    rows.push_back(stim(OP_BEGIN, 8'hFF, 10'h3FF, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_PAYLOAD, 8'h00, 10'h000, 1'b0, 32'h0000_0000, 15'd0));
    rows.push_back(stim(OP_PAYLOAD, 8'h00, 10'h000, 1'b0, 32'hFFFF_FFFF, 15'd0));
    rows.push_back(stim(OP_BEGIN, 8'h00, 10'h3FF, 1'b1, 32'h0, 15'd0));
    rows.push_back(stim(OP_BEGIN, 8'h01, 10'h000, 1'b1, 32'h0, 15'd0));
    rows.push_back(stim(OP_PAYLOAD, 8'h00, 10'h000, 1'b0, 32'hA5A5_A5A5, 15'd0));
    rows.push_back(stim(OP_PAYLOAD, 8'h00, 10'h000, 1'b0, 32'h5A5A_5A5A, 15'd0));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1026));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1025));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1027));
    rows.push_back(stim(op_e'(OP_UNUSED_LO), 8'hFF, 10'h3FF, 1'b1, 32'hFFFF_FFFF, 15'h7FFF));
    rows.push_back(stim(op_e'(OP_UNUSED_HI), 8'h00, 10'h000, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_NEW_BLOCK, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1285,
                        1'b1, KIND_READ, 32'h00FF_FFFF));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1287));
    rows.push_back(stim(OP_FLUSH, 8'h00, 10'h000, 1'b0, 32'h0, 15'd0));
    rows.push_back(stim(OP_READ, 8'h00, 10'h000, 1'b0, 32'h0, 15'd1282));
    foreach (rows[i]) push_item(rows[i].item, rows[i].fixed, rows[i].want);

    // long output hold-off while reads keep coming, so the input side backs up
    hold_req = 1'b1;
    repeat (10) push_item(make_random(1'b1));

    // three idle mixes, each after a quiet base address change
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: write_base(LINK_W'($urandom_range(0, BASE_TOP)));
        1: write_base('0);
        default: write_base(LINK_W'($urandom_range(0, BASE_TOP)));
      endcase
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 26 : 0;
      n = 0;
      while (n < PHASE_ITEMS) begin
        it = make_random(1'b0);
        push_item(it);
        if (it.operation inside {OP_NEW_BLOCK, OP_BEGIN, OP_PAYLOAD, OP_FLUSH, OP_READ}) n++;
      end
    end

    // drain and let any trailing table sweep finish
    settle();
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors += awaited_results.size();
    end
    $display("run: %0d transactions in, %0d results checked, %0d of them list starts",
             items_in, results_seen, flushes_seen);
    $display("run: %0d base writes, ring wrapped %0d times by a table, %0d by a primitive",
             base_writes, block_wraps, prim_wraps);
    if (errors == 0) begin
      $display("ordering_table_display_list_builder_tb: done, clean");
    end else begin
      $display("ordering_table_display_list_builder_tb: done, errors");
    end
    $finish;
  end

endmodule
